[hw/rtl/dsrm_pkg.sv]
// shared types, constants and helpers for the dot-star pattern matcher
`timescale 1ns / 1ps

package dsrm_pkg;

    // default number of pattern positions
    localparam int MAX_PATTERN_DEF = 32;

    // fixed field widths
    localparam int LEN_W = 6;
    localparam int IDX_W = 5;
    localparam int SYM_W = 8;

    // configuration register places
    localparam logic [0:0] REG_PATTERN_LENGTH = 1'b0;

    // special pattern bytes
    localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [SYM_W-1:0] DOT_BYTE  = 8'h2E;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_BEGIN = 2'd1,
        MODE_TEXT  = 2'd2
    } mode_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    // pattern element against one text byte
    function automatic logic element_hits(input logic [SYM_W-1:0] elem,
                                          input logic [SYM_W-1:0] c);
        element_hits = (elem == DOT_BYTE) || (elem == c);
    endfunction

endpackage

[hw/rtl/dot_star_regex_matcher.sv]
// dot-star whole-string matcher: pattern memory, row sequencer and ports
`timescale 1ns / 1ps

// Whole-string matcher for patterns of literal bytes, '.' and 'x*'.
// Input stream: tuser[1:0] is the request kind (load pattern byte, begin
// string, text byte); tdata holds pattern_index [4:0] and symbol [12:5].
// A load writes one byte into the pattern memory and gives no result.
// A begin or a text byte gives one result on the output stream:
// tdata[0] is 1 when the text so far matches the whole pattern.
// pattern_length is written over the APB port at addresses 0 to 3 (paddr[2] low).
// A begin or text byte walks the pattern one position per cycle through
// the single read port of the pattern memory, and the next request is
// taken once the result has moved into the output register.
// Reset clears the match row, the length and all handshake state; the
// pattern memory is not cleared and must be loaded before use.
// A stalled receiver holds the result in the output register; one further
// request is worked on and waits in the sequencer until the slot frees.
module dot_star_regex_matcher #(
    parameter int MAX_PATTERN = dsrm_pkg::MAX_PATTERN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pattern_index [4:0], symbol [12:5]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // matched [0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dsrm_pkg::*;

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int JW = $clog2(MAX_PATTERN + 1);
    localparam int RW = MAX_PATTERN + 1;

    // input field split
    logic [IDX_W-1:0] in_idx;
    logic [SYM_W-1:0] in_sym;
    logic [1:0]       in_mode;
    logic             in_acc;

    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_sym  = s_tdata[IDX_W+SYM_W-1:IDX_W];
    assign in_mode = s_tuser;
    assign in_acc  = s_tvalid && s_tready;

    // configuration register
    logic [LEN_W-1:0] length_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PATTERN_LENGTH);
    assign prdata = (paddr[2] == REG_PATTERN_LENGTH) ? {{(32-LEN_W){1'b0}}, length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (cfg_wr)
        begin
            length_reg <= pwdata[LEN_W-1:0];
        end
    end

    // active length, clipped to the store depth
    logic [JW-1:0] n_cur;
    assign n_cur = (32'(length_reg) > 32'(MAX_PATTERN)) ? JW'(MAX_PATTERN)
                                                       : JW'(32'(length_reg));

    // state and sequencer registers
    state_t          state_reg, state_next;
    logic [AW-1:0]   pos_reg;
    logic [JW-1:0]   n_reg;
    logic            is_text_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] prev_elem_reg;
    logic [RW-1:0]   row_reg;
    logic [RW-1:0]   new_row_reg;
    logic            result_reg;
    logic            out_valid_reg;
    logic            out_data_reg;

    // pattern memory with registered read
    logic [SYM_W-1:0] mem [MAX_PATTERN];
    logic [SYM_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             mem_wr;
    logic [AW-1:0]    wr_addr;

    assign mem_wr  = in_acc && (in_mode == MODE_LOAD) && (32'(in_idx) < 32'(MAX_PATTERN));
    assign wr_addr = AW'(32'(in_idx));
    assign rd_addr = (state_reg == ST_RUN) ? AW'(32'(pos_reg) + 1) : '0;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_addr] <= in_sym;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // one row position per cycle
    logic [JW-1:0] j_cur, jm1, jm2;
    logic          is_star, step_bit, last_step;
    logic [RW-1:0] new_row_upd;

    assign j_cur     = JW'(32'(pos_reg) + 1);
    assign jm1       = JW'(32'(pos_reg));
    assign jm2       = JW'(32'(pos_reg) - 1);
    assign is_star   = (rd_data_reg == STAR_BYTE);
    assign last_step = (j_cur == n_reg);

    always_comb
    begin
        if (is_star)
        begin
            step_bit = (pos_reg != '0) &&
                       (new_row_reg[jm2] ||
                        (is_text_reg && row_reg[j_cur] &&
                         element_hits(prev_elem_reg, sym_reg)));
        end
        else
        begin
            step_bit = is_text_reg && row_reg[jm1] && element_hits(rd_data_reg, sym_reg);
        end
        new_row_upd        = new_row_reg;
        new_row_upd[j_cur] = step_bit;
    end

    // output slot
    logic out_free;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    // next state and handshake
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (in_mode == MODE_BEGIN || in_mode == MODE_TEXT))
                begin
                    state_next = (n_cur == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // row and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_RUN && last_step)
            begin
                row_reg <= new_row_upd;
            end
            else if (state_reg == ST_IDLE && in_acc && n_cur == '0 &&
                     (in_mode == MODE_BEGIN || in_mode == MODE_TEXT))
            begin
                row_reg <= (in_mode == MODE_BEGIN) ? RW'(1) : '0;
            end
        end
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                pos_reg       <= '0;
                n_reg         <= n_cur;
                is_text_reg   <= (in_mode == MODE_TEXT);
                sym_reg       <= in_sym;
                new_row_reg   <= (in_mode == MODE_BEGIN) ? RW'(1) : '0;
                result_reg    <= (in_mode == MODE_BEGIN);
            end
            ST_RUN:
            begin
                pos_reg       <= AW'(32'(pos_reg) + 1);
                prev_elem_reg <= rd_data_reg;
                new_row_reg   <= new_row_upd;
                result_reg    <= step_bit;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= result_reg;
                end
            end
            default:
            begin
                pos_reg <= '0;
            end
        endcase
    end

    // checks
    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (j_cur <= n_reg))
        else $error("row walk past active length");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_acc && in_mode == MODE_LOAD) |=> (state_reg == ST_IDLE))
        else $error("pattern load started a row update");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished row");

    a_run_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && last_step) |=> (state_reg == ST_DONE))
        else $error("row walk did not finish");

endmodule
